FILE: rtl/core/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants, types and codes for the max-heap priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

	// store geometry
	localparam int HEAP_DEPTH = 16;
	localparam int IDX_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int KID_W      = IDX_W + 2;

	// word field widths
	localparam int CMD_W    = 2;
	localparam int PRIO_W   = 16;
	localparam int TAG_W    = 16;
	localparam int YEAR_W   = 12;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// operation codes
	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// count value of a full store as seen on the result word
	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(HEAP_DEPTH);
	localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(HEAP_DEPTH);

	// one heap entry
	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
		logic [YEAR_W-1:0]        year;
	} entry_t;

	// read address selection for the store
	typedef enum logic [1:0] {
		RD_BLD,
		RD_EXT,
		RD_KIDS
	} rd_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic    capture;
		logic    load_wr;
		logic    set_full;
		logic    set_empty;
		logic    bld_init;
		logic    bld_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cur_from_bld;
		logic    ext_load;
		logic    sift_step;
		logic    push;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             full;
		logic             empty;
		logic             bld_zero;
		logic             sift_done;
		logic             res_busy;
	} dp_stat_t;

	// entry count onto the result word, masked to its width
	function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
		return COUNT_W'(c);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mhpq_in_if.sv
// ----------------------------------------------------------------------------
// mhpq_in_if
// Request channel: valid/ready handshake with the operation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_in_if;

	logic                                  valid;
	logic                                  ready;
	logic [mhpq_pkg::CMD_W-1:0]            cmd;
	logic signed [mhpq_pkg::PRIO_W-1:0]    prio;
	logic [mhpq_pkg::TAG_W-1:0]            owner_tag;
	logic [mhpq_pkg::YEAR_W-1:0]           built_year;

	modport source (output valid, cmd, prio, owner_tag, built_year, input ready);
	modport sink   (input valid, cmd, prio, owner_tag, built_year, output ready);
	modport mon    (input valid, ready, cmd, prio, owner_tag, built_year);

endinterface

`default_nettype wire

FILE: rtl/core/mhpq_out_if.sv
// ----------------------------------------------------------------------------
// mhpq_out_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_out_if;

	logic                                  valid;
	logic                                  ready;
	logic [mhpq_pkg::STATUS_W-1:0]         status;
	logic signed [mhpq_pkg::PRIO_W-1:0]    out_prio;
	logic [mhpq_pkg::TAG_W-1:0]            out_owner_tag;
	logic [mhpq_pkg::YEAR_W-1:0]           out_year;
	logic [mhpq_pkg::COUNT_W-1:0]          entry_count;

	modport source (output valid, status, out_prio, out_owner_tag, out_year, entry_count,
		input ready);
	modport sink   (input valid, status, out_prio, out_owner_tag, out_year, entry_count,
		output ready);
	modport mon    (input valid, ready, status, out_prio, out_owner_tag, out_year,
		entry_count);

endinterface

`default_nettype wire

FILE: rtl/core/mhpq_datapath.sv
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap store, entry count, sift registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mhpq_pkg::dp_cmd_t                  cmd,
	output mhpq_pkg::dp_stat_t                      stat,
	input  wire logic [mhpq_pkg::CMD_W-1:0]         req_cmd,
	input  wire mhpq_pkg::entry_t                   req_entry,
	input  wire logic                               rsp_ready,
	output logic                                    rsp_valid,
	output logic [mhpq_pkg::STATUS_W-1:0]           rsp_status,
	output mhpq_pkg::entry_t                        rsp_entry,
	output logic [mhpq_pkg::COUNT_W-1:0]            rsp_count
);

	localparam int IW = mhpq_pkg::IDX_W;
	localparam int CW = mhpq_pkg::CNT_W;
	localparam int KW = mhpq_pkg::KID_W;

	mhpq_pkg::entry_t mem_q [mhpq_pkg::HEAP_DEPTH];

	logic [CW-1:0]                   cnt_q;
	logic [IW-1:0]                   node_q;
	logic [IW-1:0]                   bld_q;
	logic [mhpq_pkg::CMD_W-1:0]      op_q;
	mhpq_pkg::entry_t                in_q;
	mhpq_pkg::entry_t                cur_q;
	mhpq_pkg::entry_t                rd_a_q;
	mhpq_pkg::entry_t                rd_b_q;
	logic [mhpq_pkg::STATUS_W-1:0]   status_q;
	mhpq_pkg::entry_t                res_q;
	logic                            res_valid_q;
	logic [mhpq_pkg::STATUS_W-1:0]   out_status_q;
	mhpq_pkg::entry_t                out_entry_q;
	logic [mhpq_pkg::COUNT_W-1:0]    out_count_q;

	logic [KW-1:0]      kid_l;
	logic [KW-1:0]      kid_r;
	logic               l_ok;
	logic               r_ok;
	logic               pick_l;
	logic               pick_r;
	mhpq_pkg::entry_t   best;
	logic [IW-1:0]      best_idx;
	logic [IW-1:0]      rd_addr_a;
	logic [IW-1:0]      rd_addr_b;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	mhpq_pkg::entry_t   wr_data;

	// children of the current node and the larger of node/left/right
	always_comb begin
		kid_l    = KW'({node_q, 1'b1});
		kid_r    = kid_l + KW'(1);
		l_ok     = kid_l < KW'(cnt_q);
		r_ok     = kid_r < KW'(cnt_q);
		pick_l   = 1'b0;
		pick_r   = 1'b0;
		best     = cur_q;
		best_idx = node_q;
		if (l_ok && (best.prio < rd_a_q.prio)) begin
			best     = rd_a_q;
			best_idx = kid_l[IW-1:0];
			pick_l   = 1'b1;
		end
		if (r_ok && (best.prio < rd_b_q.prio)) begin
			best     = rd_b_q;
			best_idx = kid_r[IW-1:0];
			pick_r   = 1'b1;
		end
	end

	// read address mux
	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (cmd.rd_sel)
			mhpq_pkg::RD_BLD: begin
				rd_addr_a = bld_q - IW'(1);
			end
			mhpq_pkg::RD_EXT: begin
				rd_addr_b = IW'(cnt_q - CW'(1));
			end
			mhpq_pkg::RD_KIDS: begin
				rd_addr_a = kid_l[IW-1:0];
				rd_addr_b = kid_r[IW-1:0];
			end
			default: begin
				rd_addr_a = '0;
			end
		endcase
	end

	// write port: append on load, hole fill during sift
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = cur_q;
		if (cmd.load_wr) begin
			wr_en   = 1'b1;
			wr_addr = IW'(cnt_q);
			wr_data = in_q;
		end else if (cmd.sift_step) begin
			wr_en   = 1'b1;
			wr_data = best;
		end
	end

	// heap store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load_wr) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.ext_load) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.push) begin
				res_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// operation and sift registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req_cmd;
			in_q     <= req_entry;
			status_q <= mhpq_pkg::ST_OK;
			res_q    <= '0;
		end
		if (cmd.set_full) begin
			status_q <= mhpq_pkg::ST_FULL;
		end
		if (cmd.set_empty) begin
			status_q <= mhpq_pkg::ST_EMPTY;
		end
		if (cmd.bld_init) begin
			bld_q <= IW'(cnt_q >> 1);
		end else if (cmd.bld_dec) begin
			bld_q <= bld_q - IW'(1);
		end
		if (cmd.cur_from_bld) begin
			cur_q  <= rd_a_q;
			node_q <= bld_q;
		end
		if (cmd.ext_load) begin
			res_q  <= rd_a_q;
			cur_q  <= rd_b_q;
			node_q <= '0;
		end
		if (cmd.sift_step && (pick_l || pick_r)) begin
			node_q <= best_idx;
		end
	end

	// output register, loaded when the word is handed over
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= status_q;
			out_entry_q  <= res_q;
			out_count_q  <= mhpq_pkg::to_count(cnt_q);
		end
	end

	// status toward the controller
	always_comb begin
		stat.op        = op_q;
		stat.full      = cnt_q == mhpq_pkg::CNT_FULL;
		stat.empty     = cnt_q == '0;
		stat.bld_zero  = bld_q == '0;
		stat.sift_done = !(pick_l || pick_r);
		stat.res_busy  = res_valid_q && !rsp_ready;
	end

	assign rsp_valid  = res_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_entry  = out_entry_q;
	assign rsp_count  = out_count_q;

endmodule

`default_nettype wire

FILE: rtl/core/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for load, build and extract; drives the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire mhpq_pkg::dp_stat_t   stat,
	output mhpq_pkg::dp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_BLD_NEXT,
		S_BLD_LD,
		S_EXT_LD,
		S_SFT_RD,
		S_SFT_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;
	logic   ready_d;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		ready_d = ready_q;
		cmd     = '0;
		cmd.rd_sel = mhpq_pkg::RD_KIDS;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.capture = 1'b1;
					ready_d     = 1'b0;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				case (stat.op)
					mhpq_pkg::CMD_LOAD: begin
						if (stat.full) begin
							cmd.set_full = 1'b1;
						end else begin
							cmd.load_wr = 1'b1;
						end
						state_d = S_DONE;
					end
					mhpq_pkg::CMD_BUILD: begin
						cmd.bld_init = 1'b1;
						state_d      = S_BLD_NEXT;
					end
					mhpq_pkg::CMD_EXTRACT: begin
						if (stat.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = S_DONE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = mhpq_pkg::RD_EXT;
							state_d    = S_EXT_LD;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_BLD_NEXT: begin
				if (stat.bld_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.bld_dec = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = mhpq_pkg::RD_BLD;
					state_d     = S_BLD_LD;
				end
			end
			S_BLD_LD: begin
				cmd.cur_from_bld = 1'b1;
				state_d          = S_SFT_RD;
			end
			S_EXT_LD: begin
				cmd.ext_load = 1'b1;
				state_d      = S_SFT_RD;
			end
			S_SFT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = mhpq_pkg::RD_KIDS;
				state_d    = S_SFT_CMP;
			end
			S_SFT_CMP: begin
				cmd.sift_step = 1'b1;
				if (!stat.sift_done) begin
					state_d = S_SFT_RD;
				end else if (stat.op == mhpq_pkg::CMD_BUILD) begin
					state_d = S_BLD_NEXT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.res_busy) begin
					cmd.push = 1'b1;
					ready_d  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= ready_d;
		end
	end

	assign in_ready = ready_q;

endmodule

`default_nettype wire

FILE: rtl/core/max_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Binary max-heap of 16 entries with load, build and extract operations.
// ----------------------------------------------------------------------------
// Takes one request word at a time and returns exactly one response word for
// each. Load appends an unordered entry; build heap-orders the store by
// sifting down every parent from the last one back to the root; extract
// returns the root, moves the last entry up and sifts it down. Each sift
// round is a registered two-port read of both children, then compare and
// write back, and the last round is the one that finds nothing to swap. The
// next request is taken once the response is in the output register; the
// response waits there without stalling the core unless a second one is
// ready before it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mhpq_in_if.sink    req,
	mhpq_out_if.source rsp
);

	mhpq_pkg::dp_cmd_t  dp_cmd;
	mhpq_pkg::dp_stat_t dp_stat;
	mhpq_pkg::entry_t   req_entry;
	mhpq_pkg::entry_t   rsp_entry;

	// pack the request word into a store entry
	assign req_entry.prio = req.prio;
	assign req_entry.tag  = req.owner_tag;
	assign req_entry.year = req.built_year;

	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	mhpq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.req_cmd    (req.cmd),
		.req_entry  (req_entry),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_entry  (rsp_entry),
		.rsp_count  (rsp.entry_count)
	);

	// unpack the result entry
	assign rsp.out_prio      = rsp_entry.prio;
	assign rsp.out_owner_tag = rsp_entry.tag;
	assign rsp.out_year      = rsp_entry.year;

endmodule

`default_nettype wire

FILE: rtl/core/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the heap core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker (
	input wire logic   clk,
	input wire logic   arst_n,
	mhpq_in_if.sink    req,
	mhpq_out_if.source rsp
);

	// one request in flight: ready drops after every accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one still in progress");

	// a stalled response word stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
			&& $stable(rsp.entry_count) && $stable(rsp.out_prio))
		else $error("stalled response changed");

	// extract on an empty heap returns zeros and an empty count
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == mhpq_pkg::ST_EMPTY |->
			rsp.entry_count == '0 && rsp.out_prio == '0
			&& rsp.out_owner_tag == '0 && rsp.out_year == '0)
		else $error("empty response carries data or nonzero count");

	// full status only with a full store
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == mhpq_pkg::ST_FULL |->
			rsp.entry_count == mhpq_pkg::FULL_COUNT)
		else $error("full status with store not full");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

`default_nettype wire

FILE: test/max_heap_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core_tb
// Self-checking bench for the max-heap priority queue core.
// ----------------------------------------------------------------------------
// Words go in on the request channel and come back one for one on the
// response channel. A behavioral heap inside the bench tracks the store and
// the entry count, and works out the expected response of every accepted
// word; responses are compared field by field in order. A short table of
// directed words comes first (empty, full, ties, extremes, unused command),
// then random load / build / extract sequences with some noise mixed in.
// Both channels idle at random, the receiver holds off once for a long
// stretch so the core backs up, and the sender once waits for a full drain.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_core_tb;

	import mhpq_pkg::*;

	// command value the core ignores
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int RANDOM_WORDS = 1600;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 300;

	// one response word
	typedef struct {
		logic [STATUS_W-1:0]      status;
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
		logic [YEAR_W-1:0]        year;
		logic [COUNT_W-1:0]       count;
	} heap_rsp_t;

	// one row of the directed table; the answer is used only where pinned
	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
		logic [YEAR_W-1:0]        year;
		bit                       pinned;
		logic [STATUS_W-1:0]      w_status;
		logic signed [PRIO_W-1:0] w_prio;
		logic [TAG_W-1:0]         w_tag;
		logic [YEAR_W-1:0]        w_year;
		logic [COUNT_W-1:0]       w_count;
	} heap_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mhpq_in_if  req_bus ();
	mhpq_out_if rsp_bus ();

	max_heap_priority_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// generous ceiling on the whole run
	initial begin
		#6000000;
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// behavioral heap
	// ------------------------------------------------------------------
	entry_t      heap_model [HEAP_DEPTH];
	int unsigned heap_fill = 0;
	heap_rsp_t   pending_q [$];
	bit          failed = 1'b0;
	int          words_sent = 0;
	int          rsp_seen = 0;

	function automatic void sift_model(int unsigned node);
		int unsigned top;
		int unsigned lf;
		int unsigned rt;
		entry_t      t;
		while (node < heap_fill) begin
			top = node;
			lf  = 2 * node + 1;
			rt  = 2 * node + 2;
			// left child first, strict compare keeps ties in place
			if (lf < heap_fill && $signed(heap_model[top].prio) < $signed(heap_model[lf].prio))
				top = lf;
			if (rt < heap_fill && $signed(heap_model[top].prio) < $signed(heap_model[rt].prio))
				top = rt;
			if (top == node)
				break;
			t               = heap_model[node];
			heap_model[node] = heap_model[top];
			heap_model[top]  = t;
			node = top;
		end
	endfunction

	function automatic heap_rsp_t apply_heap_op(logic [CMD_W-1:0] cmd, entry_t e);
		heap_rsp_t   r;
		int unsigned i;
		r.status = ST_OK;
		r.prio   = '0;
		r.tag    = '0;
		r.year   = '0;
		case (cmd)
			CMD_LOAD: begin
				if (heap_fill >= HEAP_DEPTH)
					r.status = ST_FULL;
				else begin
					heap_model[heap_fill] = e;
					heap_fill++;
				end
			end
			CMD_BUILD: begin
				i = heap_fill / 2;
				while (i > 0) begin
					i--;
					sift_model(i);
				end
			end
			CMD_EXTRACT: begin
				if (heap_fill == 0)
					r.status = ST_EMPTY;
				else begin
					r.prio = heap_model[0].prio;
					r.tag  = heap_model[0].tag;
					r.year = heap_model[0].year;
					heap_model[0] = heap_model[heap_fill - 1];
					heap_fill--;
					sift_model(0);
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(heap_fill);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	heap_row_t dir_rows [25] = '{
		'{CMD_EXTRACT, 16'sh0000, 16'h0000, 12'h000, 1'b1, ST_EMPTY, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_BUILD,   16'sh0000, 16'h0000, 12'h000, 1'b1, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_UNUSED,  16'sh7fff, 16'hffff, 12'hfff, 1'b1, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh7fff, 16'hffff, 12'hfff, 1'b1, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd1},
		'{CMD_BUILD,   16'sh0000, 16'h0000, 12'h000, 1'b1, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd1},
		'{CMD_EXTRACT, 16'sh0000, 16'h0000, 12'h000, 1'b1,
			ST_OK, 16'sh7fff, 16'hffff, 12'hfff, 5'd0},
		'{CMD_LOAD,    16'sh8000, 16'h0000, 12'h000, 1'b1, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd1},
		// equal priorities with distinct tags show tie handling
		'{CMD_LOAD,    16'sh0005, 16'h0101, 12'h001, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0005, 16'h0102, 12'h002, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'shffff, 16'h0103, 12'h003, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh7fff, 16'h0104, 12'h004, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0005, 16'h0105, 12'h005, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh8000, 16'h0106, 12'h006, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0000, 16'h0107, 12'h007, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0064, 16'h0108, 12'h800, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0005, 16'h0109, 12'h009, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh7fff, 16'h010a, 12'h00a, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'shfffe, 16'h010b, 12'h00b, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0000, 16'h010c, 12'h00c, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0007, 16'h010d, 12'h00d, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh0064, 16'h010e, 12'h00e, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_LOAD,    16'sh8001, 16'h010f, 12'h00f, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		// store is full now
		'{CMD_LOAD,    16'sh1234, 16'h5678, 12'h9ab, 1'b1,
			ST_FULL, 16'sh0, 16'h0, 12'h0, FULL_COUNT},
		'{CMD_BUILD,   16'sh0000, 16'h0000, 12'h000, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0},
		'{CMD_EXTRACT, 16'sh0000, 16'h0000, 12'h000, 1'b0, ST_OK, 16'sh0, 16'h0, 12'h0, 5'd0}
	};

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	// offer one word from a falling edge; returns on the falling edge after
	// it was taken, with the expected response queued
	task automatic send_word(input logic [CMD_W-1:0] cmd, input entry_t e,
		input bit pinned, input heap_rsp_t pinned_rsp);
		bit        calm;
		heap_rsp_t r;
		calm = (words_sent >= 600 && words_sent < 800);
		while (!calm && $urandom_range(99) < 18) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.cmd        <= cmd;
		req_bus.prio       <= e.prio;
		req_bus.owner_tag  <= e.tag;
		req_bus.built_year <= e.year;
		do
			@(posedge clk);
		while (!req_bus.ready);
		r = apply_heap_op(cmd, e);
		pending_q.push_back(pinned ? pinned_rsp : r);
		if (cmd != CMD_UNUSED)
			words_sent++;
		@(negedge clk);
	endtask

	function automatic entry_t rand_entry();
		entry_t e;
		// narrow priorities make ties common
		if ($urandom_range(2) == 0)
			e.prio = PRIO_W'($signed($urandom_range(6)) - 3);
		else
			e.prio = PRIO_W'($urandom);
		e.tag  = TAG_W'($urandom);
		e.year = YEAR_W'($urandom);
		return e;
	endfunction

	initial begin
		heap_rsp_t   pin;
		entry_t      e;
		int          n;
		bit          paused;
		arst_n             = 1'b0;
		req_bus.valid      = 1'b0;
		req_bus.cmd        = CMD_LOAD;
		req_bus.prio       = '0;
		req_bus.owner_tag  = '0;
		req_bus.built_year = '0;
		paused             = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			e.prio      = dir_rows[i].prio;
			e.tag       = dir_rows[i].tag;
			e.year      = dir_rows[i].year;
			pin.status  = dir_rows[i].w_status;
			pin.prio    = dir_rows[i].w_prio;
			pin.tag     = dir_rows[i].w_tag;
			pin.year    = dir_rows[i].w_year;
			pin.count   = dir_rows[i].w_count;
			send_word(dir_rows[i].cmd, e, dir_rows[i].pinned, pin);
		end

		// random sequences
		while (words_sent < RANDOM_WORDS) begin
			if (!paused && words_sent >= 1000) begin
				// let everything drain before going on
				paused = 1'b1;
				req_bus.valid <= 1'b0;
				@(negedge clk);
				while (pending_q.size() != 0)
					@(negedge clk);
			end
			case ($urandom_range(9))
				7, 8: begin
					// noise: any command, any order
					n = $urandom_range(1, 8);
					repeat (n)
						send_word(CMD_W'($urandom_range(3)), rand_entry(), 1'b0, pin);
				end
				9: begin
					// drain to empty and one past it
					n = heap_fill + 1;
					repeat (n)
						send_word(CMD_EXTRACT, rand_entry(), 1'b0, pin);
				end
				default: begin
					// fill, order, take some out
					n = $urandom_range(0, HEAP_DEPTH + 2);
					repeat (n)
						send_word(CMD_LOAD, rand_entry(), 1'b0, pin);
					send_word(CMD_BUILD, rand_entry(), 1'b0, pin);
					n = $urandom_range(1, heap_fill + 2);
					repeat (n)
						send_word(CMD_EXTRACT, rand_entry(), 1'b0, pin);
				end
			endcase
		end
		req_bus.valid <= 1'b0;

		// wait for the tail, then a margin for any stray response
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		bit held_once;
		hold_left     = 0;
		held_once     = 1'b0;
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_bus.ready <= 1'b0;
				hold_left--;
			end else if (!held_once && rsp_seen >= 300) begin
				// long hold-off so the core backs up into its input
				held_once = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_bus.ready <= 1'b0;
			end else if (rsp_seen >= 1200 && rsp_seen < 1400)
				rsp_bus.ready <= 1'b1;
			else
				rsp_bus.ready <= ($urandom_range(99) >= 18);
		end
	end

	task automatic match_field(input string name, input int want, input int got);
		if (want != got) begin
			failed = 1'b1;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endtask

	// compare every taken response with the oldest expectation
	always @(posedge clk) begin
		heap_rsp_t w;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			rsp_seen++;
			if (pending_q.size() == 0) begin
				failed = 1'b1;
				$error("response word with nothing expected");
			end else begin
				w = pending_q.pop_front();
				match_field("status", w.status, rsp_bus.status);
				match_field("out_prio", $signed(w.prio), $signed(rsp_bus.out_prio));
				match_field("out_owner_tag", w.tag, rsp_bus.out_owner_tag);
				match_field("out_year", w.year, rsp_bus.out_year);
				match_field("entry_count", w.count, rsp_bus.entry_count);
			end
		end
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_in_if.sv
rtl/core/mhpq_out_if.sv
rtl/core/mhpq_datapath.sv
rtl/core/mhpq_ctrl.sv
rtl/core/max_heap_priority_queue_core.sv
rtl/core/mhpq_checker.sv
test/max_heap_priority_queue_core_tb.sv
